[sv/pbcc_pkg.sv]
// Shared constants, codes and types for the power budget core cutoff block.
package pbcc_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int CORE_W  = 4;
	localparam int POWER_W = 16;
	localparam int LIMIT_W = 20;
	localparam int CUT_W   = 4;

	// defaults
	localparam int                 CORES_DEF  = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 20'd80;
	localparam logic [CUT_W-1:0]   CUTOFF_MAX = 4'd15;

	// event codes; the spare code behaves as a query
	typedef enum logic [OP_W-1:0] {
		OP_RUN   = 2'd0,
		OP_STOP  = 2'd1,
		OP_QUERY = 2'd2,
		OP_SPARE = 2'd3
	} pbcc_op_t;

	// scan unit status back to the sequencer
	typedef struct packed {
		logic             done;
		logic [CUT_W-1:0] cutoff;
	} pbcc_scan_res_t;

endpackage

[sv/pbcc_if.sv]
// Channel interfaces: event words in, result words out, limit register writes.
interface pbcc_item_if;
	logic                            valid;
	logic                            ready;
	logic [pbcc_pkg::OP_W-1:0]       operation;
	logic [pbcc_pkg::CORE_W-1:0]     core_index;
	logic [pbcc_pkg::POWER_W-1:0]    power_value;

	modport source (output valid, output operation, output core_index,
		output power_value, input ready);
	modport sink (input valid, input operation, input core_index,
		input power_value, output ready);
endinterface

interface pbcc_result_if;
	logic                          valid;
	logic                          ready;
	logic [pbcc_pkg::CUT_W-1:0]    cutoff;
	logic                          serve_user;

	modport source (output valid, output cutoff, output serve_user, input ready);
	modport sink (input valid, input cutoff, input serve_user, output ready);
endinterface

interface pbcc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pbcc_pkg::LIMIT_W-1:0]  power_limit;

	modport source (output valid, output power_limit, input ready);
	modport sink (input valid, input power_limit, output ready);
endinterface

[sv/pbcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pbcc_ram #(
	parameter int WIDTH = pbcc_pkg::POWER_W,
	parameter int DEPTH = pbcc_pkg::CORES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/pbcc_table.sv]
// Per-core power table: RAM plus per-entry valid bits so reset reads as zero.
module pbcc_table #(
	parameter int CORES = pbcc_pkg::CORES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic                         clr_en,
	input  logic [$clog2(CORES)-1:0]     wr_addr,
	input  logic [pbcc_pkg::POWER_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(CORES)-1:0]     rd_addr,
	output logic [pbcc_pkg::POWER_W-1:0] rd_data
);

	logic [CORES-1:0]             valid_q;
	logic                         rvalid_s1;
	logic [pbcc_pkg::POWER_W-1:0] ram_rdata;

	pbcc_ram #(
		.WIDTH (pbcc_pkg::POWER_W),
		.DEPTH (CORES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// written entries become valid, a cleared core drops back to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (clr_en) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	// valid bit follows the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else if (rd_en) begin
			rvalid_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_data = rvalid_s1 ? ram_rdata : '0;

endmodule

[sv/pbcc_scan.sv]
// Scan unit: one shared add and compare walks the table, one entry per cycle.
module pbcc_scan #(
	parameter int CORES = pbcc_pkg::CORES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pbcc_pkg::LIMIT_W-1:0]  limit,
	output logic                          rd_en,
	output logic [$clog2(CORES)-1:0]      rd_addr,
	input  logic [pbcc_pkg::POWER_W-1:0]  rd_data,
	output pbcc_pkg::pbcc_scan_res_t      res
);

	localparam int AW   = $clog2(CORES);
	localparam int CNTW = $clog2(CORES + 1);
	localparam int SW   = pbcc_pkg::POWER_W + AW;
	localparam int CMPW = (SW > pbcc_pkg::LIMIT_W) ? SW : pbcc_pkg::LIMIT_W;

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic            pend_s1;
	logic [AW-1:0]   idx_s1;
	logic [SW-1:0]   sum_q;
	logic [SW-1:0]   sum_next;
	logic            over;
	logic            last;
	logic            done;

	// read issue: one address per cycle until the table is exhausted or the scan is done
	assign rd_en   = busy_q && (cnt_q < CNTW'(CORES));
	assign rd_addr = cnt_q[AW-1:0];

	// shared accumulate and compare on the returning entry
	assign sum_next = sum_q + SW'(rd_data);
	assign over     = CMPW'(sum_next) > CMPW'(limit);
	assign last     = idx_s1 == AW'(CORES - 1);
	assign done     = pend_s1 && (over || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (done) begin
			busy_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= '0;
		end else if (pend_s1) begin
			sum_q <= sum_next;
		end
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
	end

	// stop index, saturated to the cutoff field
	always_comb begin
		res.done = done;
		if (idx_s1 > AW'(pbcc_pkg::CUTOFF_MAX)) begin
			res.cutoff = pbcc_pkg::CUTOFF_MAX;
		end else begin
			res.cutoff = pbcc_pkg::CUT_W'(idx_s1);
		end
	end

endmodule

[sv/power_budget_core_cutoff_unit.sv]
// Top level: event sequencer, cutoff and limit registers, result register.
//
//  channel  dir  handshake     payload
//  item     in   valid/ready   operation, core_index, power_value
//  result   out  valid/ready   cutoff, serve_user
//  cfg      in   valid/ready   power_limit (ready always high)
//
// One word at a time. A stop or query word goes from the update state to the result
// state; a run word passes through the table scan between the two, paced by the
// single table read port and the shared add/compare unit.
// arst_n clears the table (valid bits), cutoff to 0, limit to 80; no clearing pass.
// A result held by a stalled consumer keeps item.ready low until it is taken.
module power_budget_core_cutoff_unit #(
	parameter int CORES = pbcc_pkg::CORES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pbcc_item_if.sink            item,
	pbcc_result_if.source        result,
	pbcc_cfg_if.sink             cfg
);

	localparam int AW = $clog2(CORES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [pbcc_pkg::OP_W-1:0]       op_q;
	logic [pbcc_pkg::CORE_W-1:0]     core_q;
	logic [pbcc_pkg::POWER_W-1:0]    power_q;
	logic [pbcc_pkg::LIMIT_W-1:0]    limit_q;
	logic [pbcc_pkg::CUT_W-1:0]      cutoff_q;
	logic                            serve_q;
	logic                            in_range;
	logic                            tbl_wr;
	logic                            tbl_clr;
	logic                            scan_start;
	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	logic [pbcc_pkg::POWER_W-1:0]    rd_data;
	pbcc_pkg::pbcc_scan_res_t        scan_res;

	assign item.ready = state_q == ST_IDLE;
	assign cfg.ready  = 1'b1;

	// table side effects in the update cycle
	assign in_range   = int'(core_q) < CORES;
	assign tbl_wr     = (state_q == ST_UPD) && (op_q == pbcc_pkg::OP_RUN) && in_range;
	assign tbl_clr    = (state_q == ST_UPD) && (op_q == pbcc_pkg::OP_STOP) && in_range;
	assign scan_start = (state_q == ST_UPD) && (op_q == pbcc_pkg::OP_RUN);

	pbcc_table #(
		.CORES (CORES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.clr_en  (tbl_clr),
		.wr_addr (AW'(core_q)),
		.wr_data (power_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pbcc_scan #(
		.CORES (CORES)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.limit   (limit_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (scan_res)
	);

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pbcc_pkg::LIMIT_RST;
		end else if (cfg.valid) begin
			limit_q <= cfg.power_limit;
		end
	end

	// captured event word
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_q    <= item.operation;
			core_q  <= item.core_index;
			power_q <= item.power_value;
		end
	end

	// sequencer, cutoff and serve flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cutoff_q <= '0;
			serve_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					case (op_q)
						pbcc_pkg::OP_RUN: begin
							serve_q <= 1'b0;
							state_q <= ST_SCAN;
						end
						pbcc_pkg::OP_STOP: begin
							serve_q <= 1'b0;
							state_q <= ST_OUT;
						end
						default: begin
							serve_q <= core_q <= cutoff_q;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						cutoff_q <= scan_res.cutoff;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = state_q == ST_OUT;
	assign result.cutoff     = cutoff_q;
	assign result.serve_user = serve_q;

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !item.ready)
		else $error("word accepted while a result is pending");

	a_cutoff_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cutoff_q) |-> $past(scan_res.done))
		else $error("cutoff changed without a finished scan");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> state_q == ST_SCAN)
		else $error("scan finished outside the scan state");

	a_accept_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q == ST_UPD)
		else $error("accepted word did not enter the update cycle");
`endif

endmodule

[bench/tb_power_budget_core_cutoff_unit.sv]
// Testbench for the power budget core cutoff unit: scoreboard, drivers and checks.
module tb_power_budget_core_cutoff_unit;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 100;

	typedef logic [pbcc_pkg::CORE_W-1:0]  core_t;
	typedef logic [pbcc_pkg::POWER_W-1:0] power_t;
	typedef logic [pbcc_pkg::LIMIT_W-1:0] limit_t;

	// scoreboard: mirrors the power table and cutoff, queues expected results
	class cutoff_scoreboard;
		typedef struct packed {
			logic [pbcc_pkg::CUT_W-1:0] cutoff;
			logic                       serve_user;
		} outcome_t;

		logic [pbcc_pkg::POWER_W-1:0] core_power[pbcc_pkg::CORES_DEF];
		logic [pbcc_pkg::CUT_W-1:0]   cutoff_now;
		logic [pbcc_pkg::LIMIT_W-1:0] budget;
		outcome_t                     pending_outcomes[$];
		int                           errors;

		function new();
			foreach (core_power[i])
				core_power[i] = '0;
			cutoff_now = '0;
			budget = pbcc_pkg::LIMIT_RST;
			errors = 0;
		endfunction

		function void set_budget(logic [pbcc_pkg::LIMIT_W-1:0] v);
			budget = v;
		endfunction

		function int pending_count();
			return pending_outcomes.size();
		endfunction

		// first core where the running sum goes over budget, else the last core
		function logic [pbcc_pkg::CUT_W-1:0] scan_cutoff();
			int unsigned sum;
			int unsigned found;
			sum = 0;
			found = pbcc_pkg::CORES_DEF - 1;
			for (int i = 0; i < pbcc_pkg::CORES_DEF; i++) begin
				sum += core_power[i];
				if (sum > budget) begin
					found = i;
					break;
				end
			end
			if (found > pbcc_pkg::CUTOFF_MAX)
				found = pbcc_pkg::CUTOFF_MAX;
			return found[pbcc_pkg::CUT_W-1:0];
		endfunction

		// accepted event word: update the mirror and queue its result
		function void note_word(pbcc_pkg::pbcc_op_t op, logic [pbcc_pkg::CORE_W-1:0] core,
				logic [pbcc_pkg::POWER_W-1:0] pw);
			outcome_t o;
			o.serve_user = 1'b0;
			case (op)
				pbcc_pkg::OP_RUN: begin
					core_power[core] = pw;
					cutoff_now = scan_cutoff();
				end
				pbcc_pkg::OP_STOP: begin
					core_power[core] = '0;
				end
				default: begin
					o.serve_user = (core <= cutoff_now);
				end
			endcase
			o.cutoff = cutoff_now;
			pending_outcomes.push_back(o);
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("mismatch on %s: got %0d, expected %0d (t=%0t)",
				what, got, want, $time);
			errors++;
		endtask

		// accepted result word: compare against the oldest expectation
		task check_result(logic [pbcc_pkg::CUT_W-1:0] cut, logic serve);
			outcome_t o;
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result word, cutoff", cut, 0);
			end else begin
				o = pending_outcomes.pop_front();
				if (cut !== o.cutoff)
					report_mismatch("cutoff", cut, o.cutoff);
				if (serve !== o.serve_user)
					report_mismatch("serve_user", serve, o.serve_user);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	bit   idle_on;
	bit   tail;

	cutoff_scoreboard sb = new();

	pbcc_item_if   item_ch();
	pbcc_result_if res_ch();
	pbcc_cfg_if    cfg_ch();

	power_budget_core_cutoff_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.cutoff, res_ch.serve_user);
	end

	// result side back-pressure in bursts, none in the tail
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!tail && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// one event word; optional idle burst afterwards
	task automatic send_word(pbcc_pkg::pbcc_op_t op, logic [pbcc_pkg::CORE_W-1:0] core,
			logic [pbcc_pkg::POWER_W-1:0] pw);
		item_ch.valid       <= 1'b1;
		item_ch.operation   <= op;
		item_ch.core_index  <= core;
		item_ch.power_value <= pw;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_word(op, core, pw);
		if (idle_on && !tail && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// wait for every outstanding result, then let the block settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// limit register write, only while the block is idle
	task automatic write_limit(logic [pbcc_pkg::LIMIT_W-1:0] v);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.power_limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_budget(v);
		cfg_ch.valid <= 1'b0;
	endtask

	// power value scaled to the budget so the cutoff moves around
	function automatic power_t pick_power(limit_t lim);
		int unsigned sel;
		int unsigned span;
		sel = $urandom_range(0, 9);
		span = lim / 4 + 1;
		if (span > 65535)
			span = 65535;
		case (sel)
			0:       return '0;
			1:       return '1;
			2, 3:    return power_t'($urandom_range(0, 65535));
			default: return power_t'($urandom_range(0, span));
		endcase
	endfunction

	function automatic pbcc_pkg::pbcc_op_t pick_op();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel <= 8)
			return pbcc_pkg::OP_RUN;
		else if (sel <= 12)
			return pbcc_pkg::OP_STOP;
		else if (sel <= 18)
			return pbcc_pkg::OP_QUERY;
		else
			return pbcc_pkg::OP_SPARE;
	endfunction

	// main sequence
	initial begin
		limit_t lim;
		arst_n = 1'b0;
		idle_on = 1'b0;
		tail = 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.operation   <= pbcc_pkg::OP_QUERY;
		item_ch.core_index  <= '0;
		item_ch.power_value <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.power_limit  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset budget
		send_word(pbcc_pkg::OP_QUERY, 4'd0, 16'hFFFF); // reset cutoff is 0: core 0 may serve
		send_word(pbcc_pkg::OP_QUERY, 4'd15, 16'd0);
		send_word(pbcc_pkg::OP_SPARE, 4'd0, 16'd0);    // spare code acts as a query
		send_word(pbcc_pkg::OP_SPARE, 4'd1, 16'hFFFF);
		send_word(pbcc_pkg::OP_RUN, 4'd0, 16'd0);      // sum never over budget: last core
		send_word(pbcc_pkg::OP_QUERY, 4'd15, 16'd0);
		send_word(pbcc_pkg::OP_RUN, 4'd3, 16'd81);     // over budget at core 3
		send_word(pbcc_pkg::OP_STOP, 4'd3, 16'hFFFF);  // stop keeps the cutoff
		send_word(pbcc_pkg::OP_QUERY, 4'd4, 16'd0);
		send_word(pbcc_pkg::OP_QUERY, 4'd3, 16'd0);
		send_word(pbcc_pkg::OP_RUN, 4'd15, 16'hFFFF);
		send_word(pbcc_pkg::OP_RUN, 4'd0, 16'd80);     // equal to budget is not over
		send_word(pbcc_pkg::OP_RUN, 4'd1, 16'd1);
		send_word(pbcc_pkg::OP_RUN, 4'd0, 16'd81);
		send_word(pbcc_pkg::OP_RUN, 4'd7, 16'd0);
		send_word(pbcc_pkg::OP_STOP, 4'd0, 16'd0);
		send_word(pbcc_pkg::OP_QUERY, 4'd1, 16'd0);
		send_word(pbcc_pkg::OP_RUN, 4'd15, 16'd0);
		send_word(pbcc_pkg::OP_STOP, 4'd15, 16'd0);
		send_word(pbcc_pkg::OP_STOP, 4'd1, 16'd0);
		send_word(pbcc_pkg::OP_QUERY, 4'd15, 16'd0);
		drain();

		// random phases, one budget each, extremes first
		for (int p = 0; p < 7; p++) begin
			case (p)
				0:       lim = '0;
				1:       lim = '1;
				2:       lim = limit_t'($urandom_range(1, 255));
				3:       lim = limit_t'($urandom_range(256, 65535));
				4:       lim = limit_t'($urandom_range(65536, 1048574));
				5:       lim = pbcc_pkg::LIMIT_RST;
				default: lim = limit_t'($urandom_range(0, 4095));
			endcase
			tail = (p == 6);
			write_limit(lim);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 25 == 0)
					idle_on = ($urandom_range(0, 2) != 0);
				send_word(pick_op(), core_t'($urandom_range(0, 15)), pick_power(lim));
			end
			drain();
		end

		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
